/* rtl/sac_pkg.sv */
// Shared types and codes for the set-associative cache tag controller.
// No dependencies.
package sac_pkg;

    typedef enum logic [1:0] {
        REQ_STATUS    = 2'd0,
        REQ_WRITEBACK = 2'd1,
        REQ_FILL      = 2'd2,
        REQ_WRITE     = 2'd3
    } req_kind_t;

    localparam logic [0:0] CFG_REPLACEMENT_MODE = 1'b0;
    localparam logic [0:0] CFG_WRITE_MODE       = 1'b1;

    localparam logic       CMD_WRITE = 1'b1;
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_MASK = 16'hB400;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_LOOKUP = 2'd1,
        ST_EMIT   = 2'd2
    } back_state_t;

    // One classified access as it crosses from the front to the back.
    typedef struct packed {
        logic        is_write;
        logic [31:0] address;
        logic [3:0]  byte_count;
        logic [63:0] write_data;
    } access_t;

endpackage

/* rtl/set_assoc_cache_tag_controller.sv */
// Top level of the tag-only set-associative cache controller.
// Instantiates sac_front and sac_back; depends on sac_pkg.
//
// An accepted access enters a two-entry queue, from which the back end takes
// it when idle. The back end works on an access in steps (queue pop and tag
// read, lookup and update, result load, result transfer), with a further load
// and transfer for each further result, and waits while the result side
// stalls; the tag store is read per access and written on a fill.
// The queue lets accesses arrive while one is worked on.
// Results of one access share hit and the counter values; tlast marks the
// final one. Valid and dirty bits clear at reset, so no clearing pass runs.
module set_assoc_cache_tag_controller
    import sac_pkg::*;
#(
    parameter int NUM_SETS    = 64,
    parameter int BLOCK_BYTES = 32,
    parameter int WAYS        = 4,
    parameter int ADDR_BITS   = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [0:0]   cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // command, address[32], byte_count[4], write_data[64], pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [207:0] m_tdata,   // request_kind[2], mem_address[32], mem_length[6],
                                    // mem_data[64], hit, hit/miss/writeback totals, pad
    output logic         m_tlast
);

    logic    repl_reg, wmode_reg;
    access_t in_acc, q_acc;
    logic    q_valid, q_ready;
    logic [1:0]  kind;
    logic [31:0] maddr, ht, mt, wt;
    logic [5:0]  mlen;
    logic [63:0] mdata;
    logic        mhit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repl_reg  <= 1'b0;
            wmode_reg <= 1'b0;
        end else if (cfg_we) begin
            if (cfg_index == CFG_REPLACEMENT_MODE) repl_reg <= cfg_data[0];
            if (cfg_index == CFG_WRITE_MODE)       wmode_reg <= cfg_data[0];
        end
    end

    assign in_acc.is_write   = s_tdata[0];
    assign in_acc.address    = s_tdata[32:1];
    assign in_acc.byte_count = s_tdata[36:33];
    assign in_acc.write_data = s_tdata[100:37];

    sac_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_access(in_acc),
        .q_valid, .q_ready, .q_access(q_acc)
    );

    sac_back #(
        .NUM_SETS(NUM_SETS), .BLOCK_BYTES(BLOCK_BYTES),
        .WAYS(WAYS), .ADDR_BITS(ADDR_BITS)
    ) u_back (
        .aclk, .aresetn,
        .replacement_mode(repl_reg), .write_mode(wmode_reg),
        .q_valid, .q_ready, .q_access(q_acc),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .m_kind(kind), .m_address(maddr), .m_length(mlen), .m_data(mdata),
        .m_hit(mhit), .m_last(m_tlast),
        .m_hit_total(ht), .m_miss_total(mt), .m_wb_total(wt)
    );

    assign m_tdata = {7'd0, wt, mt, ht, mhit, mdata, mlen, maddr, kind};

endmodule

/* rtl/sac_front.sv */
// Front end: accepts accesses, clamps the byte count, masks the data and
// queues them for the back end. Depends on sac_pkg.
module sac_front
    import sac_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  access_t        in_access,
    output logic           q_valid,
    input  logic           q_ready,
    output access_t        q_access
);

    access_t  slot_reg [2];
    logic [1:0] count_reg;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    access_t    cooked;
    logic [3:0] nb;
    logic       push;
    logic       pop;

    always_comb begin
        nb = (in_access.byte_count > 4'd8) ? 4'd8 : in_access.byte_count;
        cooked = in_access;
        cooked.byte_count = nb;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) >= nb) begin
                cooked.write_data[b*8 +: 8] = 8'd0;
            end
        end
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_access = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= cooked;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

/* rtl/sac_back.sv */
// Back end: tag lookup, victim choice, state update and request emission.
// Holds the tag, valid and dirty stores. Depends on sac_pkg.
module sac_back
    import sac_pkg::*;
#(
    parameter int NUM_SETS    = 64,
    parameter int BLOCK_BYTES = 32,
    parameter int WAYS        = 4,
    parameter int ADDR_BITS   = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        replacement_mode,
    input  logic        write_mode,
    input  logic        q_valid,
    output logic        q_ready,
    input  access_t     q_access,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [31:0] m_address,
    output logic [5:0]  m_length,
    output logic [63:0] m_data,
    output logic        m_hit,
    output logic        m_last,
    output logic [31:0] m_hit_total,
    output logic [31:0] m_miss_total,
    output logic [31:0] m_wb_total
);

    localparam int OFF_BITS = $clog2(BLOCK_BYTES);
    localparam int SET_BITS = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int SET_USED = $clog2(NUM_SETS);
    localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_BITS = ADDR_BITS - OFF_BITS - SET_USED;
    localparam int LINES    = NUM_SETS * WAYS;
    localparam int LINE_BITS = $clog2(LINES) > 0 ? $clog2(LINES) : 1;

    logic [TAG_BITS-1:0] tag_mem [NUM_SETS][WAYS];
    logic [TAG_BITS-1:0] rd_tag_reg [WAYS];
    logic [LINES-1:0]    valid_reg;
    logic [LINES-1:0]    dirty_reg;

    back_state_t state_reg, state_next;
    access_t     acc_reg;
    logic [15:0] lfsr_reg;
    logic [31:0] hit_cnt_reg, miss_cnt_reg, wb_cnt_reg;
    logic [ADDR_BITS-1:0] addr_cut;
    logic [SET_BITS-1:0]  set_idx;
    logic [SET_BITS-1:0]  q_set;
    logic [TAG_BITS-1:0]  acc_tag;
    logic                 hit_any;
    logic [WAY_BITS-1:0]  hit_way, vic_way;
    logic [LINE_BITS-1:0] hit_line, vic_line;
    logic                 wt_write, need_wb;
    logic [2:0]           plan_reg;
    logic [31:0]          wb_addr_reg, fill_addr;
    logic                 hit_flag_reg;
    logic                 out_valid_reg;
    logic [1:0]           out_kind_reg;
    logic [31:0]          out_addr_reg;
    logic [5:0]           out_len_reg;
    logic [63:0]          out_data_reg;
    logic                 out_last_reg;
    logic                 take;
    logic                 lookup_done;
    logic                 out_free;
    logic                 emit_go;
    logic [ADDR_BITS-1:0] wb_full;

    assign q_set   = SET_BITS'(ADDR_BITS'(q_access.address) >> OFF_BITS)
                     & SET_BITS'(NUM_SETS - 1);
    assign addr_cut = ADDR_BITS'(acc_reg.address);
    assign set_idx = SET_BITS'(addr_cut >> OFF_BITS) & SET_BITS'(NUM_SETS - 1);
    assign acc_tag = TAG_BITS'(addr_cut >> (OFF_BITS + SET_USED));
    assign wt_write = acc_reg.is_write && write_mode;
    assign vic_way = replacement_mode ? WAY_BITS'(lfsr_reg % WAYS) : '0;
    assign vic_line = LINE_BITS'(set_idx * WAYS) + LINE_BITS'(vic_way);
    assign hit_line = LINE_BITS'(set_idx * WAYS) + LINE_BITS'(hit_way);
    assign need_wb = valid_reg[vic_line] && dirty_reg[vic_line];
    assign fill_addr = 32'(addr_cut) & ~32'(BLOCK_BYTES - 1);
    assign wb_full = (ADDR_BITS'(rd_tag_reg[vic_way]) << (OFF_BITS + SET_USED))
                     | (ADDR_BITS'(set_idx) << OFF_BITS);

    always_comb begin
        hit_any = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (valid_reg[LINE_BITS'(set_idx * WAYS) + LINE_BITS'(w)]
                && rd_tag_reg[w] == acc_tag) begin
                hit_any = 1'b1;
                hit_way = WAY_BITS'(w);
            end
        end
    end

    assign out_free = !out_valid_reg || m_ready;
    assign q_ready  = (state_reg == ST_IDLE);
    assign take     = q_valid && q_ready;
    assign lookup_done = (state_reg == ST_LOOKUP);
    assign emit_go  = (state_reg == ST_EMIT) && out_free && (plan_reg != 3'd0);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (q_valid) state_next = ST_LOOKUP;
            ST_LOOKUP: state_next = ST_EMIT;
            ST_EMIT:   if (out_free && plan_reg == 3'd0) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            acc_reg <= q_access;
            for (int w = 0; w < WAYS; w++) begin
                rd_tag_reg[w] <= tag_mem[q_set][w];
            end
        end
        if (lookup_done && !hit_any && !wt_write) begin
            tag_mem[set_idx][vic_way] <= acc_tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            lfsr_reg      <= LFSR_SEED;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            wb_cnt_reg    <= '0;
            plan_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= emit_go ? 1'b1 : (out_valid_reg && !m_ready);
            if (lookup_done) begin
                hit_flag_reg <= hit_any;
                wb_addr_reg  <= 32'(wb_full);
                if (hit_any) begin
                    hit_cnt_reg <= hit_cnt_reg + 32'd1;
                    plan_reg    <= 3'b100;
                    if (acc_reg.is_write && !write_mode) dirty_reg[hit_line] <= 1'b1;
                end else begin
                    miss_cnt_reg <= miss_cnt_reg + 32'd1;
                    if (wt_write) begin
                        plan_reg <= 3'b100;
                    end else begin
                        if (replacement_mode) begin
                            lfsr_reg <= (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_MASK : 16'd0);
                        end
                        if (need_wb) wb_cnt_reg <= wb_cnt_reg + 32'd1;
                        plan_reg <= {1'b0, 1'b1, need_wb};
                        valid_reg[vic_line] <= 1'b1;
                        dirty_reg[vic_line] <= acc_reg.is_write;
                    end
                end
            end else if (emit_go) begin
                out_data_reg  <= '0;
                if (plan_reg[0]) begin
                    plan_reg     <= {plan_reg[2:1], 1'b0};
                    out_kind_reg <= REQ_WRITEBACK;
                    out_addr_reg <= wb_addr_reg;
                    out_len_reg  <= 6'(BLOCK_BYTES);
                    out_last_reg <= 1'b0;
                end else if (plan_reg[1]) begin
                    plan_reg     <= '0;
                    out_kind_reg <= REQ_FILL;
                    out_addr_reg <= fill_addr;
                    out_len_reg  <= 6'(BLOCK_BYTES);
                    out_last_reg <= 1'b1;
                end else begin
                    plan_reg     <= '0;
                    out_last_reg <= 1'b1;
                    if (wt_write) begin
                        out_kind_reg <= REQ_WRITE;
                        out_addr_reg <= 32'(addr_cut);
                        out_len_reg  <= 6'(acc_reg.byte_count);
                        out_data_reg <= acc_reg.write_data;
                    end else begin
                        out_kind_reg <= REQ_STATUS;
                        out_addr_reg <= '0;
                        out_len_reg  <= '0;
                    end
                end
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_kind       = out_kind_reg;
    assign m_address    = out_addr_reg;
    assign m_length     = out_len_reg;
    assign m_data       = out_data_reg;
    assign m_hit        = hit_flag_reg;
    assign m_last       = out_last_reg;
    assign m_hit_total  = hit_cnt_reg;
    assign m_miss_total = miss_cnt_reg;
    assign m_wb_total   = wb_cnt_reg;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the set-associative cache tag controller.
// It predicts every result of each accepted access and checks it against the
// block's output stream, under several settings and idling patterns. Uses sac_pkg.
`timescale 1ns / 100ps

module testbench;
    import sac_pkg::*;

    typedef struct {
        logic        is_write;
        logic [31:0] address;
        logic [3:0]  byte_count;
        logic [63:0] write_data;
    } access_item_t;

    typedef struct {
        req_kind_t   kind;
        logic [31:0] mem_address;
        logic [5:0]  mem_length;
        logic [63:0] mem_data;
        logic        hit;
        logic        last;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] writeback_total;
    } mem_request_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [0:0]   cfg_index = '0;
    logic [0:0]   cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [207:0] m_tdata;
    logic         m_tlast;

    set_assoc_cache_tag_controller u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always #10 aclk = ~aclk;

    // Predictor state.
    logic [20:0] tag_mem [256];
    logic        valid_mem [256];
    logic        dirty_mem [256];
    logic [15:0] victim_lfsr;
    logic [31:0] hits, misses, writebacks;
    logic        random_victim, write_through;

    access_item_t pending_accesses[$];
    mem_request_t expected_requests[$];
    access_item_t driven;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int transfers_in = 0;
    int transfers_out = 0;

    function automatic void predict_access(access_item_t a);
        logic [5:0]   set;
        logic [20:0]  tag;
        logic [3:0]   nb;
        logic [63:0]  data;
        int           way;
        int           idx;
        mem_request_t r;
        mem_request_t batch[$];
        set = a.address[10:5];
        tag = a.address[31:11];
        nb = (a.byte_count > 4'd8) ? 4'd8 : a.byte_count;
        data = (nb == 4'd8) ? a.write_data : (a.write_data & ((64'd1 << (nb * 8)) - 64'd1));
        r.kind = REQ_STATUS; r.mem_address = '0; r.mem_length = '0; r.mem_data = '0;
        r.hit = 1'b0; r.last = 1'b0;
        for (way = 0; way < 4; way++) begin
            idx = set * 4 + way;
            if (valid_mem[idx] && tag_mem[idx] == tag) begin
                hits++;
                r.hit = 1'b1;
                if (a.is_write && write_through) begin
                    r.kind = REQ_WRITE; r.mem_address = a.address;
                    r.mem_length = {2'b0, nb}; r.mem_data = data;
                end else if (a.is_write) begin
                    dirty_mem[idx] = 1'b1;
                end
                batch.push_back(r);
                break;
            end
        end
        if (batch.size() == 0) begin
            misses++;
            if (a.is_write && write_through) begin
                r.kind = REQ_WRITE; r.mem_address = a.address;
                r.mem_length = {2'b0, nb}; r.mem_data = data;
                batch.push_back(r);
            end else begin
                way = 0;
                if (random_victim) begin
                    way = victim_lfsr[1:0];
                    victim_lfsr = victim_lfsr[0] ? ((victim_lfsr >> 1) ^ LFSR_MASK)
                                                 : (victim_lfsr >> 1);
                end
                idx = set * 4 + way;
                if (valid_mem[idx] && dirty_mem[idx]) begin
                    writebacks++;
                    r.kind = REQ_WRITEBACK; r.mem_address = {tag_mem[idx], set, 5'b0};
                    r.mem_length = 6'd32;
                    batch.push_back(r);
                end
                tag_mem[idx] = tag;
                valid_mem[idx] = 1'b1;
                dirty_mem[idx] = a.is_write;
                r.kind = REQ_FILL; r.mem_address = {a.address[31:5], 5'b0};
                r.mem_length = 6'd32;
                batch.push_back(r);
            end
        end
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i]) begin
            batch[i].hit_total = hits;
            batch[i].miss_total = misses;
            batch[i].writeback_total = writebacks;
            expected_requests.push_back(batch[i]);
        end
    endfunction

    // Driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_access(driven);
                transfers_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_accesses.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    driven = pending_accesses.pop_front();
                    s_tdata <= {3'b0, driven.write_data, driven.byte_count,
                                driven.address, driven.is_write};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch on %s at transfer %0d: expected %h, got %h",
                         name, transfers_out, exp_v, act_v);
        end
    endfunction

    // Monitor.
    always @(posedge aclk) begin
        mem_request_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_requests.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result transfer: %h", m_tdata);
                end else begin
                    e = expected_requests.pop_front();
                    check_field("request_kind", e.kind, m_tdata[1:0]);
                    check_field("mem_address", e.mem_address, m_tdata[33:2]);
                    check_field("mem_length", e.mem_length, m_tdata[39:34]);
                    check_field("mem_data", e.mem_data, m_tdata[103:40]);
                    check_field("hit", e.hit, m_tdata[104]);
                    check_field("last", e.last, m_tlast);
                    check_field("hit_total", e.hit_total, m_tdata[136:105]);
                    check_field("miss_total", e.miss_total, m_tdata[168:137]);
                    check_field("writeback_total", e.writeback_total, m_tdata[200:169]);
                end
                transfers_out++;
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(logic [0:0] index, logic value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        if (index == CFG_REPLACEMENT_MODE) random_victim = value;
        else write_through = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_accesses.size() > 0 || s_tvalid || expected_requests.size() > 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic add_access(logic w, logic [31:0] a, logic [3:0] n, logic [63:0] d);
        access_item_t it;
        it.is_write = w; it.address = a; it.byte_count = n; it.write_data = d;
        pending_accesses.push_back(it);
    endtask

    task automatic add_random(int count);
        logic [31:0] a;
        logic [3:0]  n;
        repeat (count) begin
            if ($urandom_range(99) < 85)
                a = {21'($urandom_range(7) ^ (32'h1F_0000 * $urandom_range(1))),
                     6'($urandom_range(3) ^ (32'h3C * $urandom_range(1))), 5'($urandom)};
            else
                a = $urandom;
            n = ($urandom_range(99) < 85) ? 4'($urandom_range(1, 8)) : 4'($urandom);
            add_access(1'($urandom_range(1)), a, n, {$urandom, $urandom});
        end
    endtask

    initial begin
        int phase;
        foreach (valid_mem[i]) begin
            valid_mem[i] = 1'b0;
            dirty_mem[i] = 1'b0;
            tag_mem[i] = '0;
        end
        victim_lfsr = LFSR_SEED;
        hits = '0; misses = '0; writebacks = '0;
        random_victim = 1'b0; write_through = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_reg(CFG_REPLACEMENT_MODE, 1'b0);
        write_reg(CFG_WRITE_MODE, 1'b0);

        // Directed: extremes, hits, dirty evictions, odd byte counts.
        add_access(1'b0, 32'h0000_0000, 4'd1, 64'd0);
        add_access(1'b0, 32'h0000_0004, 4'd8, 64'd0);
        add_access(1'b1, 32'h0000_0008, 4'd8, '1);
        add_access(1'b1, 32'h0000_0800, 4'd4, '1);
        add_access(1'b1, 32'h0000_0000, 4'd0, '1);
        add_access(1'b0, 32'hFFFF_FFFF, 4'd15, '1);
        add_access(1'b1, 32'hFFFF_FFE0, 4'd9, 64'h0123_4567_89AB_CDEF);
        add_access(1'b1, 32'hFFFF_F7E0, 4'd2, '1);
        wait_drained();
        write_reg(CFG_WRITE_MODE, 1'b1);
        add_access(1'b1, 32'hFFFF_F7E3, 4'd3, '1);
        add_access(1'b1, 32'h1234_5678, 4'd0, '1);
        add_access(1'b1, 32'h1234_5678, 4'd15, '1);
        add_access(1'b1, 32'h0000_0010, 4'd8, '1);
        add_access(1'b0, 32'h0000_1000, 4'd1, 64'd0);
        add_access(1'b0, 32'hFFFF_FFFC, 4'd4, 64'd0);
        wait_drained();
        write_reg(CFG_REPLACEMENT_MODE, 1'b1);
        add_access(1'b0, 32'hAAAA_AAAA, 4'd5, '1);
        add_access(1'b1, 32'h5555_5555, 4'd7, 64'hA5A5_5A5A_F0F0_0F0F);
        wait_drained();

        for (phase = 0; phase < 6; phase++) begin
            send_idle_pct = (phase < 2) ? 37 : (phase < 4) ? 65 : 0;
            recv_idle_pct = (phase < 2) ? 65 : (phase < 4) ? 37 : 0;
            write_reg(CFG_REPLACEMENT_MODE, phase[0]);
            write_reg(CFG_WRITE_MODE, phase == 1 || phase == 4);
            add_random(40);
            wait_drained();
        end

        $display("Ran %0d accesses and checked %0d result transfers, %0d hits, %0d misses,",
                 transfers_in, transfers_out, hits, misses);
        $display("%0d write-backs, over both victim and both write modes.", writebacks);
        if (mismatches == 0 && expected_requests.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
